FILE: design/tracker_pattern_command_decoder_macros.svh
// Assertion macros for the tracker pattern command decoder checks.
`ifndef TRACKER_PATTERN_COMMAND_DECODER_MACROS_SVH
`define TRACKER_PATTERN_COMMAND_DECODER_MACROS_SVH

// Clocked check, masked while reset is asserted (active-low reset).
`define TPCD_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define TPCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tpcd_pkg.sv
// Shared types and constants of the tracker pattern command decoder.
package tpcd_pkg;

  typedef enum logic [3:0] {
    EV_SAMPLE     = 4'd0,
    EV_REST       = 4'd1,
    EV_NOTE       = 4'd2,
    EV_ENV_OFF    = 4'd3,
    EV_ENVELOPE   = 4'd4,
    EV_QUIT       = 4'd5,
    EV_ORNAMENT   = 4'd6,
    EV_VOLUME     = 4'd7,
    EV_TEMPO      = 4'd8,
    EV_GLISS      = 4'd9,
    EV_NOTE_GLISS = 4'd10,
    EV_GLISS_OFF  = 4'd11,
    EV_NOISE_ADD  = 4'd12
  } event_kind_t;

  // Command whose operand bytes are being collected.
  typedef enum logic [5:0] {
    PEND_NONE   = 6'b000001,
    PEND_ENV    = 6'b000010,
    PEND_TEMPO  = 6'b000100,
    PEND_GLISS  = 6'b001000,
    PEND_NGLISS = 6'b010000,
    PEND_NOISE  = 6'b100000
  } pend_t;

  localparam logic [7:0] CMD_NONE       = 8'h00;
  localparam logic [7:0] CMD_NOISE_LO   = 8'h01;
  localparam logic [7:0] CMD_NOISE_HI   = 8'h0B;
  localparam logic [7:0] CMD_GLISS_OFF  = 8'h0C;
  localparam logic [7:0] CMD_NGLISS     = 8'h0D;
  localparam logic [7:0] CMD_GLISS      = 8'h0E;
  localparam logic [7:0] CMD_TEMPO      = 8'h0F;
  localparam logic [7:0] CMD_VOLUME_LO  = 8'h10;
  localparam logic [7:0] CMD_VOLUME_HI  = 8'h1F;
  localparam logic [7:0] CMD_SKIP_LO    = 8'h20;
  localparam logic [7:0] CMD_SKIP_HI    = 8'h5F;
  localparam logic [7:0] CMD_ORN_LO     = 8'h60;
  localparam logic [7:0] CMD_ORN_HI     = 8'h6F;
  localparam logic [7:0] CMD_QUIT       = 8'h70;
  localparam logic [7:0] CMD_ENV_LO     = 8'h71;
  localparam logic [7:0] CMD_ENV_HI     = 8'h7E;
  localparam logic [7:0] CMD_ENV_OFF    = 8'h7F;
  localparam logic [7:0] CMD_NOTE_LO    = 8'h80;
  localparam logic [7:0] CMD_NOTE_HI    = 8'hDF;
  localparam logic [7:0] CMD_REST       = 8'hE0;
  localparam logic [7:0] CMD_SAMPLE_LO  = 8'hE1;
  localparam logic [7:0] CMD_SAMPLE_HI  = 8'hFF;

  localparam logic [1:0] OPS_ONE   = 2'd1;
  localparam logic [1:0] OPS_TWO   = 2'd2;
  localparam logic [1:0] OPS_THREE = 2'd3;

endpackage

FILE: design/tracker_pattern_command_decoder.sv
// Top level of the tracker pattern command decoder.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_cmd_byte
//   out_     output     out_valid/out_ready  out_event_kind, out_small_value,
//                                            out_signed_value, out_word_value,
//                                            out_line_end, out_lines_to_wait
//
// One request per cycle sustained while results are taken; a byte passes from
// the input register through decode into the result register.
// Skip/zero commands and the early operand bytes of envelope and note-glissando commands are consumed without a result.
// Reset (rst_n low, synchronous) clears both stages and the operand state.
// A stalled result holds the result register; the input register still
// takes one more request, then in_ready drops until the result is taken.
module tracker_pattern_command_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_cmd_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_event_kind,
  output logic [7:0]         out_small_value,
  output logic signed [7:0]  out_signed_value,
  output logic [15:0]        out_word_value,
  output logic               out_line_end,
  output logic [5:0]         out_lines_to_wait
);
  import tpcd_pkg::*;

  logic        byte_valid_r;
  logic [7:0]  byte_r;

  pend_t       pend_r, pend_nxt;
  logic [1:0]  left_r, left_nxt;
  logic [1:0]  left_dec;
  logic [7:0]  held_sgn_r, held_sgn_nxt;
  logic [7:0]  held_low_r, held_low_nxt;
  logic [5:0]  skip_r, skip_nxt;
  logic [5:0]  skip_diff;

  logic        out_valid_r;
  event_kind_t kind_r;
  logic [7:0]  small_r;
  logic [7:0]  sgn_r;
  logic [15:0] word_r;
  logic        line_end_r;
  logic [5:0]  wait_r;

  logic        advance;
  logic        take;
  logic        res_valid;
  event_kind_t res_kind;
  logic [7:0]  res_small;
  logic [7:0]  res_sgn;
  logic [15:0] res_word;
  logic        res_line_end;

  assign advance  = !out_valid_r || out_ready;
  assign take     = byte_valid_r && advance;
  assign in_ready = !byte_valid_r || advance;

  assign left_dec  = left_r - 2'd1;
  assign skip_diff = byte_r[5:0] - CMD_SKIP_LO[5:0];

  always_comb begin
    pend_nxt     = pend_r;
    left_nxt     = left_r;
    held_sgn_nxt = held_sgn_r;
    held_low_nxt = held_low_r;
    skip_nxt     = skip_r;
    res_valid    = 1'b0;
    res_kind     = EV_SAMPLE;
    res_small    = 8'd0;
    res_sgn      = 8'd0;
    res_word     = 16'd0;
    res_line_end = 1'b0;

    if (left_r != 2'd0 && pend_r != PEND_NONE) begin
      // operand byte: count down, drop the pending command on the last one
      left_nxt = left_dec;
      if (left_dec == 2'd0) begin
        pend_nxt = PEND_NONE;
      end
      case (pend_r)
        PEND_TEMPO: begin
          res_valid = 1'b1;
          res_kind  = EV_TEMPO;
          res_small = byte_r;
        end
        PEND_GLISS: begin
          res_valid = 1'b1;
          res_kind  = EV_GLISS;
          res_sgn   = byte_r;
        end
        PEND_NOISE: begin
          res_valid = 1'b1;
          res_kind  = EV_NOISE_ADD;
          res_sgn   = byte_r;
        end
        PEND_ENV: begin
          if (left_r == OPS_TWO) begin
            held_low_nxt = byte_r;
          end else begin
            res_valid = 1'b1;
            res_kind  = EV_ENVELOPE;
            res_small = held_sgn_r;
            res_word  = {byte_r, held_low_r};
          end
        end
        PEND_NGLISS: begin
          if (left_r == OPS_THREE) begin
            held_sgn_nxt = byte_r;
          end else if (left_r == OPS_TWO) begin
            held_low_nxt = byte_r;
          end else begin
            res_valid = 1'b1;
            res_kind  = EV_NOTE_GLISS;
            res_sgn   = held_sgn_r;
            res_word  = {byte_r, held_low_r};
          end
        end
        default: begin
          pend_nxt = PEND_NONE;
          left_nxt = 2'd0;
        end
      endcase
    end else begin
      pend_nxt = PEND_NONE;
      left_nxt = 2'd0;
      case (byte_r) inside
        CMD_NONE: begin
        end
        [CMD_NOISE_LO:CMD_NOISE_HI]: begin
          pend_nxt = PEND_NOISE;
          left_nxt = OPS_ONE;
        end
        CMD_GLISS_OFF: begin
          res_valid = 1'b1;
          res_kind  = EV_GLISS_OFF;
        end
        CMD_NGLISS: begin
          pend_nxt = PEND_NGLISS;
          left_nxt = OPS_THREE;
        end
        CMD_GLISS: begin
          pend_nxt = PEND_GLISS;
          left_nxt = OPS_ONE;
        end
        CMD_TEMPO: begin
          pend_nxt = PEND_TEMPO;
          left_nxt = OPS_ONE;
        end
        [CMD_VOLUME_LO:CMD_VOLUME_HI]: begin
          res_valid = 1'b1;
          res_kind  = EV_VOLUME;
          res_small = byte_r - CMD_VOLUME_LO;
        end
        [CMD_SKIP_LO:CMD_SKIP_HI]: begin
          skip_nxt = skip_diff;
        end
        [CMD_ORN_LO:CMD_ORN_HI]: begin
          res_valid = 1'b1;
          res_kind  = EV_ORNAMENT;
          res_small = byte_r - CMD_ORN_LO;
        end
        CMD_QUIT: begin
          res_valid    = 1'b1;
          res_kind     = EV_QUIT;
          res_line_end = 1'b1;
        end
        [CMD_ENV_LO:CMD_ENV_HI]: begin
          held_sgn_nxt = byte_r - CMD_QUIT;
          pend_nxt     = PEND_ENV;
          left_nxt     = OPS_TWO;
        end
        CMD_ENV_OFF: begin
          res_valid = 1'b1;
          res_kind  = EV_ENV_OFF;
        end
        [CMD_NOTE_LO:CMD_NOTE_HI]: begin
          res_valid    = 1'b1;
          res_kind     = EV_NOTE;
          res_small    = byte_r - CMD_NOTE_LO;
          res_line_end = 1'b1;
        end
        CMD_REST: begin
          res_valid    = 1'b1;
          res_kind     = EV_REST;
          res_line_end = 1'b1;
        end
        [CMD_SAMPLE_LO:CMD_SAMPLE_HI]: begin
          res_valid = 1'b1;
          res_kind  = EV_SAMPLE;
          res_small = byte_r - CMD_REST;
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_ready) begin
      byte_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_cmd_byte;
    end
  end

  // operand collection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= PEND_NONE;
      left_r     <= 2'd0;
      held_sgn_r <= 8'd0;
      held_low_r <= 8'd0;
      skip_r     <= 6'd0;
    end else if (take) begin
      pend_r     <= pend_nxt;
      left_r     <= left_nxt;
      held_sgn_r <= held_sgn_nxt;
      held_low_r <= held_low_nxt;
      skip_r     <= skip_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      kind_r     <= res_kind;
      small_r    <= res_small;
      sgn_r      <= res_sgn;
      word_r     <= res_word;
      line_end_r <= res_line_end;
      wait_r     <= res_line_end ? skip_r : 6'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = kind_r;
  assign out_small_value   = small_r;
  assign out_signed_value  = sgn_r;
  assign out_word_value    = word_r;
  assign out_line_end      = line_end_r;
  assign out_lines_to_wait = wait_r;

endmodule

FILE: design/tpcd_checker.sv
// Port-level checks of the tracker pattern command decoder, bound to the top level.
`include "tracker_pattern_command_decoder_macros.svh"

module tpcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_cmd_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_event_kind,
  input logic [7:0]         out_small_value,
  input logic signed [7:0]  out_signed_value,
  input logic [15:0]        out_word_value,
  input logic               out_line_end,
  input logic [5:0]         out_lines_to_wait
);
  import tpcd_pkg::*;

  // a stalled result holds
  `TPCD_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_event_kind) && $stable(out_word_value) && $stable(out_small_value), "result changed while stalled")

  // only rest, note and quit end a line
  `TPCD_ASSERT_RST(a_line_end_kind, clk, rst_n, out_valid && out_line_end |-> out_event_kind == EV_REST || out_event_kind == EV_NOTE || out_event_kind == EV_QUIT, "line end on wrong kind")

  // wait period only shown on a line end
  `TPCD_ASSERT_RST(a_wait_zero, clk, rst_n, out_valid && !out_line_end |-> out_lines_to_wait == 6'd0, "wait period without line end")

  // no result right after reset
  `TPCD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind tracker_pattern_command_decoder tpcd_checker u_tpcd_checker (.*);

FILE: tb/tracker_pattern_command_decoder_test.sv
// Testbench for the tracker pattern command decoder: directed, random and stall tests.
`timescale 1ns / 1ps

module tracker_pattern_command_decoder_test;
  import tpcd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    event_kind_t       kind;
    logic [7:0]        level;
    logic signed [7:0] step;
    logic [15:0]       word;
    logic              line_end;
    logic [5:0]        lines;
  } pattern_event_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_cmd_byte;
  logic              out_valid;
  logic              out_ready;
  logic [3:0]        out_event_kind;
  logic [7:0]        out_small_value;
  logic signed [7:0] out_signed_value;
  logic [15:0]       out_word_value;
  logic              out_line_end;
  logic [5:0]        out_lines_to_wait;

  // Decoder state mirrored by the predictor
  pend_t      op_pend;
  logic [1:0] ops_left;
  logic [7:0] held_first;
  logic [7:0] held_low;
  logic [5:0] skip_lines;

  pattern_event_t pending_events[$];
  pattern_event_t want_ev;

  int errors;
  int bytes_sent;
  int events_checked;
  int line_ends_seen;
  int cycle_count;
  int send_max_gap;
  int recv_max_gap;
  int recv_hold;
  int stall_left;

  tracker_pattern_command_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd_byte      (in_cmd_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_small_value  (out_small_value),
    .out_signed_value (out_signed_value),
    .out_word_value   (out_word_value),
    .out_line_end     (out_line_end),
    .out_lines_to_wait(out_lines_to_wait)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events outstanding", $time, pending_events.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic pattern_event_t make_event(event_kind_t kind, logic [7:0] level,
                                                logic [7:0] step, logic [15:0] word,
                                                logic line_end);
    pattern_event_t ev;
    ev.kind     = kind;
    ev.level    = level;
    ev.step     = step;
    ev.word     = word;
    ev.line_end = line_end;
    ev.lines    = line_end ? skip_lines : 6'd0;
    return ev;
  endfunction

  // Append an expected event at the tail of the queue.
  function automatic void queue_event(pattern_event_t ev);
    pending_events.insert(pending_events.size(), ev);
  endfunction

  // Advance the mirrored state by one byte; queue the event it produces, if any.
  function automatic void decode_pattern_byte(logic [7:0] b);
    pend_t      cmd;
    logic [1:0] left;
    cmd  = op_pend;
    left = ops_left;
    if (left != 2'd0 && cmd != PEND_NONE) begin
      ops_left = left - 2'd1;
      if (ops_left == 2'd0) op_pend = PEND_NONE;
      case (cmd)
        PEND_TEMPO: queue_event(make_event(EV_TEMPO, b, 8'd0, 16'd0, 1'b0));
        PEND_GLISS: queue_event(make_event(EV_GLISS, 8'd0, b, 16'd0, 1'b0));
        PEND_NOISE: queue_event(make_event(EV_NOISE_ADD, 8'd0, b, 16'd0, 1'b0));
        PEND_ENV: begin
          if (left == OPS_TWO) held_low = b;
          else queue_event(make_event(EV_ENVELOPE, held_first, 8'd0,
                                      {b, held_low}, 1'b0));
        end
        PEND_NGLISS: begin
          if (left == OPS_THREE) held_first = b;
          else if (left == OPS_TWO) held_low = b;
          else queue_event(make_event(EV_NOTE_GLISS, 8'd0, held_first,
                                      {b, held_low}, 1'b0));
        end
        default: begin
          op_pend  = PEND_NONE;
          ops_left = 2'd0;
        end
      endcase
      return;
    end
    op_pend  = PEND_NONE;
    ops_left = 2'd0;
    if (b == CMD_NONE) begin
      // nothing
    end else if (b >= CMD_SAMPLE_LO) begin
      queue_event(make_event(EV_SAMPLE, b - CMD_REST, 8'd0, 16'd0, 1'b0));
    end else if (b == CMD_REST) begin
      queue_event(make_event(EV_REST, 8'd0, 8'd0, 16'd0, 1'b1));
    end else if (b >= CMD_NOTE_LO) begin
      queue_event(make_event(EV_NOTE, b - CMD_NOTE_LO, 8'd0, 16'd0, 1'b1));
    end else if (b == CMD_ENV_OFF) begin
      queue_event(make_event(EV_ENV_OFF, 8'd0, 8'd0, 16'd0, 1'b0));
    end else if (b >= CMD_ENV_LO) begin
      // envelope type counts up from the quit code
      held_first = b - CMD_QUIT;
      op_pend    = PEND_ENV;
      ops_left   = OPS_TWO;
    end else if (b == CMD_QUIT) begin
      queue_event(make_event(EV_QUIT, 8'd0, 8'd0, 16'd0, 1'b1));
    end else if (b >= CMD_ORN_LO) begin
      queue_event(make_event(EV_ORNAMENT, b - CMD_ORN_LO, 8'd0, 16'd0, 1'b0));
    end else if (b >= CMD_SKIP_LO) begin
      skip_lines = 6'(b - CMD_SKIP_LO);
    end else if (b >= CMD_VOLUME_LO) begin
      queue_event(make_event(EV_VOLUME, b - CMD_VOLUME_LO, 8'd0, 16'd0, 1'b0));
    end else if (b == CMD_TEMPO) begin
      op_pend  = PEND_TEMPO;
      ops_left = OPS_ONE;
    end else if (b == CMD_GLISS) begin
      op_pend  = PEND_GLISS;
      ops_left = OPS_ONE;
    end else if (b == CMD_NGLISS) begin
      op_pend  = PEND_NGLISS;
      ops_left = OPS_THREE;
    end else if (b == CMD_GLISS_OFF) begin
      queue_event(make_event(EV_GLISS_OFF, 8'd0, 8'd0, 16'd0, 1'b0));
    end else begin
      op_pend  = PEND_NOISE;
      ops_left = OPS_ONE;
    end
  endfunction

  // Called at a rising edge; returns at the edge where the request is accepted.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, send_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    decode_pattern_byte(b);
    bytes_sent++;
  endtask

  task automatic send_list(logic [7:0] seq[]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Hold the sender until every queued event has come out, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_command();
    logic [7:0] b;
    int ops;
    ops = 0;
    case ($urandom_range(0, 15))
      0: begin b = 8'($urandom_range(CMD_NOISE_LO, CMD_NOISE_HI)); ops = 1; end
      1: b = CMD_GLISS_OFF;
      2: begin b = CMD_NGLISS; ops = 3; end
      3: begin b = CMD_GLISS; ops = 1; end
      4: begin b = CMD_TEMPO; ops = 1; end
      5: b = 8'($urandom_range(CMD_VOLUME_LO, CMD_VOLUME_HI));
      6: b = 8'($urandom_range(CMD_SKIP_LO, CMD_SKIP_HI));
      7: b = 8'($urandom_range(CMD_ORN_LO, CMD_ORN_HI));
      8: b = CMD_QUIT;
      9, 10: begin b = 8'($urandom_range(CMD_ENV_LO, CMD_ENV_HI)); ops = 2; end
      11: b = CMD_ENV_OFF;
      12: b = 8'($urandom_range(CMD_NOTE_LO, CMD_NOTE_HI));
      13: b = CMD_REST;
      14: b = 8'($urandom_range(CMD_SAMPLE_LO, CMD_SAMPLE_HI));
      default: b = ($urandom_range(0, 3) == 0) ? CMD_NONE : 8'($urandom_range(0, 255));
    endcase
    send_byte(b);
    repeat (ops) send_byte(pick_operand());
  endtask

  task automatic test_command_ranges();
    send_max_gap = 17;
    recv_max_gap = 17;
    send_list('{CMD_SKIP_HI, CMD_NOTE_LO, CMD_NONE, CMD_GLISS_OFF, CMD_VOLUME_HI, CMD_ORN_LO,
                CMD_QUIT, CMD_ENV_OFF, CMD_NOTE_HI, CMD_REST, CMD_SAMPLE_LO, CMD_SAMPLE_HI});
    drain();
  endtask

  // Operands that look like commands, zero operands, extreme signed steps
  task automatic test_operand_capture();
    send_max_gap = 2;
    recv_max_gap = 0;
    send_list('{CMD_NOISE_LO, 8'h80, CMD_NGLISS, 8'h00, 8'hE0, 8'hFF, CMD_GLISS, CMD_QUIT,
                CMD_TEMPO, 8'hFF, CMD_ENV_HI, 8'h00, CMD_NGLISS});
    drain();
  endtask

  task automatic test_random_stream();
    int gaps[6][2];
    int target;
    gaps = '{'{17, 17}, '{0, 0}, '{0, 17}, '{17, 0}, '{3, 3}, '{0, 0}};
    foreach (gaps[p]) begin
      send_max_gap = gaps[p][0];
      recv_max_gap = gaps[p][1];
      target = bytes_sent + 240;
      while (bytes_sent < target) send_random_command();
      drain();
    end
  endtask

  // Stop taking events for a long stretch while requests keep coming.
  task automatic test_output_stall();
    send_max_gap = 0;
    recv_max_gap = 4;
    recv_hold    = 150;
    repeat (40) send_random_command();
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (recv_hold > 0) begin
        stall_left = recv_hold;
        recv_hold  = 0;
      end else if (out_valid && out_ready) begin
        stall_left = $urandom_range(0, recv_max_gap);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: event kind %0d with none expected", $time, out_event_kind);
      end else begin
        want_ev = pending_events.pop_front();
        check_field("event_kind", int'(want_ev.kind), int'(out_event_kind));
        check_field("small_value", int'(want_ev.level), int'(out_small_value));
        check_field("signed_value", int'(8'(want_ev.step)), int'(8'(out_signed_value)));
        check_field("word_value", int'(want_ev.word), int'(out_word_value));
        check_field("line_end", int'(want_ev.line_end), int'(out_line_end));
        check_field("lines_to_wait", int'(want_ev.lines), int'(out_lines_to_wait));
        events_checked++;
        if (out_line_end) line_ends_seen++;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd_byte  = 8'h00;
    out_ready    = 1'b0;
    op_pend      = PEND_NONE;
    ops_left     = 2'd0;
    held_first   = 8'd0;
    held_low     = 8'd0;
    skip_lines   = 6'd0;
    send_max_gap = 0;
    recv_max_gap = 0;
    recv_hold    = 0;
    stall_left   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_command_ranges();
    test_operand_capture();
    test_output_stall();
    test_random_stream();

    $display("%0d command and operand bytes sent, %0d events checked, %0d of them line ends",
             bytes_sent, events_checked, line_ends_seen);
    $display("covered every command range, operand capture and long output stalls");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
